@@ rtl/cpoc_pkg.sv @@
// Package with types and constants shared by the circle pair overlap correction core.
package cpoc_pkg;

  localparam int SQ_STEPS = 26;   // square root result bits
  localparam int W_STEPS  = 17;   // mass share quotient bits
  localparam int Q_STEPS  = 26;   // axis push quotient bits

  localparam logic [16:0] STIFF_ONE   = 17'd65536;
  localparam logic [16:0] STIFF_RESET = 17'd58982;
  localparam logic [16:0] HALF_Q16    = 17'd32768;

  // Register address index.
  localparam logic REG_STIFFNESS = 1'b0;

  typedef struct packed {
    logic        vld;
    logic [31:0] x1;
    logic [31:0] y1;
    logic [31:0] x2;
    logic [31:0] y2;
    logic [23:0] r1;
    logic [23:0] r2;
    logic        sx;
    logic        sy;
    logic [24:0] adx;
    logic [24:0] ady;
    logic [24:0] sum;
    logic        inr;
  } s1_t;

  typedef struct packed {
    logic        vld;
    logic [31:0] x1;
    logic [31:0] y1;
    logic [31:0] x2;
    logic [31:0] y2;
    logic        sx;
    logic        sy;
    logic [24:0] adx;
    logic [24:0] ady;
    logic [24:0] sum;
    logic        inr;
    logic [50:0] dist2;
    logic [49:0] sumsq;
    logic [47:0] m1;
    logic [47:0] m2;
  } s2_t;

  typedef struct packed {
    logic        vld;
    logic [31:0] x1;
    logic [31:0] y1;
    logic [31:0] x2;
    logic [31:0] y2;
    logic        sx;
    logic        sy;
    logic [24:0] adx;
    logic [24:0] ady;
    logic [24:0] sum;
    logic        ovl;
    logic [50:0] sv;
    logic [50:0] sres;
    logic [49:0] drem;
    logic [48:0] mt;
    logic [16:0] w1;
  } sq_t;

  typedef struct packed {
    logic        vld;
    logic [31:0] x1;
    logic [31:0] y1;
    logic [31:0] x2;
    logic [31:0] y2;
    logic        sx;
    logic        sy;
    logic [24:0] adx;
    logic [24:0] ady;
    logic        ovl;
    logic [25:0] dlen;
    logic [25:0] ov;
    logic [16:0] w1;
    logic [16:0] w2;
  } ov_t;

  typedef struct packed {
    logic        vld;
    logic [31:0] x1;
    logic [31:0] y1;
    logic [31:0] x2;
    logic [31:0] y2;
    logic        sx;
    logic        sy;
    logic [24:0] adx;
    logic [24:0] ady;
    logic        ovl;
    logic [25:0] dlen;
    logic [25:0] p1;
    logic [25:0] p2;
  } pp_t;

  // Lanes: first x, first y, second x, second y.
  typedef struct packed {
    logic             vld;
    logic [31:0]      x1;
    logic [31:0]      y1;
    logic [31:0]      x2;
    logic [31:0]      y2;
    logic             sx;
    logic             sy;
    logic             ovl;
    logic [25:0]      dlen;
    logic [3:0][52:0] r;
    logic [3:0][25:0] q;
  } dv_t;

  typedef struct packed {
    logic        vld;
    logic [31:0] nx1;
    logic [31:0] ny1;
    logic [31:0] nx2;
    logic [31:0] ny2;
    logic        contact;
  } out_t;

endpackage

@@ rtl/circle_pair_overlap_correction_core.sv @@
// Top level of the circle pair overlap correction core.
//
// Input words arrive on the s_axis group: each holds two circles (centers in
// signed Q15.16, radii in unsigned Q8.16). For each word one result word leaves
// on the m_axis group with both corrected centers, saturated to 32 bits, and a
// contact flag. Pairs that do not overlap, or whose centers coincide, pass
// through unchanged with contact low.
// Throughput is one word per cycle unless the receiver stalls. Each word
// passes three setup stages, 26 stages of the digit-by-digit square root
// (the mass share divider runs alongside it), three stages for the scaled
// push, 26 restoring divider stages that split the push over the axes, and
// the output stage. The square root and divider chains set the depth.
// The stiffness register sits at APB address 0 and should be written while
// the pipeline is empty. Synchronous reset empties the pipeline and loads a
// stiffness of 0.9. When the receiver stalls, the whole pipeline holds and
// s_axis_tready drops; nothing is lost or repeated.
module circle_pair_overlap_correction_core
  import cpoc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // first_x[31:0], first_y[63:32], first_radius[87:64], second_x[119:88],
  // second_y[151:120], second_radius[175:152]
  input  logic [175:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // new_first_x[31:0], new_first_y[63:32], new_second_x[95:64],
  // new_second_y[127:96], contact[128], zero fill above
  output logic [135:0] m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  logic [16:0] stiffness;
  logic        en;

  // The pipeline advances whenever the result register is free or being taken.
  assign en            = m_axis_tready || !m_axis_tvalid;
  assign s_axis_tready = en;
  assign pready        = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stiffness <= STIFF_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_STIFFNESS) begin
      stiffness <= pwdata[16:0];
    end
  end

  assign prdata = (paddr[2] == REG_STIFFNESS) ? {15'd0, stiffness} : 32'd0;

  // One square root step and, in the first steps, one mass share divider step.
  function automatic sq_t sq_step(sq_t a, int k);
    sq_t         b;
    logic [51:0] bitv;
    logic [51:0] trial;
    logic [49:0] rm;
    b     = a;
    bitv  = 52'd1 << (50 - 2 * k);
    trial = {1'b0, a.sres} + bitv;
    if ({1'b0, a.sv} >= trial) begin
      b.sv   = 51'({1'b0, a.sv} - trial);
      b.sres = 51'({1'b0, a.sres >> 1} + bitv);
    end else begin
      b.sres = a.sres >> 1;
    end
    if (k < W_STEPS) begin
      rm = (k == 0) ? a.drem : {a.drem[48:0], 1'b0};
      if (rm >= {1'b0, a.mt}) begin
        b.drem = rm - {1'b0, a.mt};
        b.w1[W_STEPS - 1 - k] = 1'b1;
      end else begin
        b.drem = rm;
      end
    end
    return b;
  endfunction

  // One restoring divider step on all four lanes.
  function automatic dv_t dv_step(dv_t a, int k);
    dv_t         b;
    logic [52:0] dsh;
    b   = a;
    dsh = 53'(a.dlen) << (Q_STEPS - 1 - k);
    for (int l = 0; l < 4; l++) begin
      if (a.r[l] >= dsh) begin
        b.r[l] = a.r[l] - dsh;
        b.q[l][Q_STEPS - 1 - k] = 1'b1;
      end
    end
    return b;
  endfunction

  function automatic logic [31:0] sat_add(logic [31:0] base, logic neg,
                                          logic [25:0] mag);
    logic signed [33:0] s;
    s = $signed({{2{base[31]}}, base}) + (neg ? -$signed({8'd0, mag})
                                              : $signed({8'd0, mag}));
    if (s > 34'sd2147483647) begin
      return 32'h7FFF_FFFF;
    end else if (s < -34'sd2147483648) begin
      return 32'h8000_0000;
    end
    return s[31:0];
  endfunction

  // Stage 1: differences and radius sum.
  s1_t s1;
  always_ff @(posedge clk) begin
    logic signed [32:0] dx, dy;
    if (rst) begin
      s1.vld <= 1'b0;
    end else if (en) begin
      dx = $signed({s_axis_tdata[31], s_axis_tdata[31:0]})
         - $signed({s_axis_tdata[119], s_axis_tdata[119:88]});
      dy = $signed({s_axis_tdata[63], s_axis_tdata[63:32]})
         - $signed({s_axis_tdata[151], s_axis_tdata[151:120]});
      s1.vld <= s_axis_tvalid;
      s1.x1  <= s_axis_tdata[31:0];
      s1.y1  <= s_axis_tdata[63:32];
      s1.r1  <= s_axis_tdata[87:64];
      s1.x2  <= s_axis_tdata[119:88];
      s1.y2  <= s_axis_tdata[151:120];
      s1.r2  <= s_axis_tdata[175:152];
      s1.sx  <= dx[32];
      s1.sy  <= dy[32];
      s1.adx <= dx[32] ? 25'(-dx) : dx[24:0];
      s1.ady <= dy[32] ? 25'(-dy) : dy[24:0];
      s1.sum <= {1'b0, s_axis_tdata[87:64]} + {1'b0, s_axis_tdata[175:152]};
      // Axis distances of 2^25 or more can never overlap.
      s1.inr <= (dx < 33'sd33554432) && (dx > -33'sd33554432)
             && (dy < 33'sd33554432) && (dy > -33'sd33554432);
    end
  end

  // Stage 2: squares.
  s2_t s2;
  always_ff @(posedge clk) begin
    if (rst) begin
      s2.vld <= 1'b0;
    end else if (en) begin
      s2.vld   <= s1.vld;
      s2.x1    <= s1.x1;
      s2.y1    <= s1.y1;
      s2.x2    <= s1.x2;
      s2.y2    <= s1.y2;
      s2.sx    <= s1.sx;
      s2.sy    <= s1.sy;
      s2.adx   <= s1.adx;
      s2.ady   <= s1.ady;
      s2.sum   <= s1.sum;
      s2.inr   <= s1.inr;
      s2.dist2 <= 51'(s1.adx * s1.adx) + 51'(s1.ady * s1.ady);
      s2.sumsq <= 50'(s1.sum * s1.sum);
      s2.m1    <= s1.r1 * s1.r1;
      s2.m2    <= s1.r2 * s1.r2;
    end
  end

  // Stage 3: overlap test and setup of the root and share chains.
  sq_t sq [0:SQ_STEPS];
  always_ff @(posedge clk) begin
    if (rst) begin
      sq[0].vld <= 1'b0;
    end else if (en) begin
      sq[0].vld  <= s2.vld;
      sq[0].x1   <= s2.x1;
      sq[0].y1   <= s2.y1;
      sq[0].x2   <= s2.x2;
      sq[0].y2   <= s2.y2;
      sq[0].sx   <= s2.sx;
      sq[0].sy   <= s2.sy;
      sq[0].adx  <= s2.adx;
      sq[0].ady  <= s2.ady;
      sq[0].sum  <= s2.sum;
      sq[0].ovl  <= s2.inr && ({1'b0, s2.sumsq} > s2.dist2) && (s2.dist2 != 51'd0);
      sq[0].sv   <= s2.dist2;
      sq[0].sres <= 51'd0;
      sq[0].drem <= {2'b00, s2.m2};
      sq[0].mt   <= {1'b0, s2.m1} + {1'b0, s2.m2};
      sq[0].w1   <= 17'd0;
    end
  end

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sq
    always_ff @(posedge clk) begin
      if (rst) begin
        sq[i + 1].vld <= 1'b0;
      end else if (en) begin
        sq[i + 1] <= sq_step(sq[i], i);
      end
    end
  end

  // Scaled overlap and the two shares.
  ov_t ovs;
  always_ff @(posedge clk) begin
    logic [16:0] st;
    logic [25:0] raw;
    logic [42:0] prod;
    if (rst) begin
      ovs.vld <= 1'b0;
    end else if (en) begin
      st   = stiffness[16] ? STIFF_ONE : stiffness;
      raw  = {1'b0, sq[SQ_STEPS].sum} - sq[SQ_STEPS].sres[25:0];
      prod = raw * st + 43'(HALF_Q16);
      ovs.vld  <= sq[SQ_STEPS].vld;
      ovs.x1   <= sq[SQ_STEPS].x1;
      ovs.y1   <= sq[SQ_STEPS].y1;
      ovs.x2   <= sq[SQ_STEPS].x2;
      ovs.y2   <= sq[SQ_STEPS].y2;
      ovs.sx   <= sq[SQ_STEPS].sx;
      ovs.sy   <= sq[SQ_STEPS].sy;
      ovs.adx  <= sq[SQ_STEPS].adx;
      ovs.ady  <= sq[SQ_STEPS].ady;
      ovs.ovl  <= sq[SQ_STEPS].ovl;
      ovs.dlen <= sq[SQ_STEPS].sres[25:0];
      ovs.ov   <= prod[41:16];
      ovs.w1   <= sq[SQ_STEPS].w1;
      ovs.w2   <= STIFF_ONE - sq[SQ_STEPS].w1;
    end
  end

  // Push of each circle.
  pp_t pp;
  always_ff @(posedge clk) begin
    logic [42:0] a1, a2;
    if (rst) begin
      pp.vld <= 1'b0;
    end else if (en) begin
      a1 = ovs.ov * ovs.w1 + 43'(HALF_Q16);
      a2 = ovs.ov * ovs.w2 + 43'(HALF_Q16);
      pp.vld  <= ovs.vld;
      pp.x1   <= ovs.x1;
      pp.y1   <= ovs.y1;
      pp.x2   <= ovs.x2;
      pp.y2   <= ovs.y2;
      pp.sx   <= ovs.sx;
      pp.sy   <= ovs.sy;
      pp.adx  <= ovs.adx;
      pp.ady  <= ovs.ady;
      pp.ovl  <= ovs.ovl;
      pp.dlen <= ovs.dlen;
      pp.p1   <= a1[41:16];
      pp.p2   <= a2[41:16];
    end
  end

  // Dividend of each axis push, rounded to nearest.
  dv_t dv [0:Q_STEPS];
  always_ff @(posedge clk) begin
    logic [52:0] half;
    if (rst) begin
      dv[0].vld <= 1'b0;
    end else if (en) begin
      half = 53'(pp.dlen >> 1);
      dv[0].vld  <= pp.vld;
      dv[0].x1   <= pp.x1;
      dv[0].y1   <= pp.y1;
      dv[0].x2   <= pp.x2;
      dv[0].y2   <= pp.y2;
      dv[0].sx   <= pp.sx;
      dv[0].sy   <= pp.sy;
      dv[0].ovl  <= pp.ovl;
      dv[0].dlen <= pp.dlen;
      dv[0].r[0] <= 53'(pp.adx * pp.p1) + half;
      dv[0].r[1] <= 53'(pp.ady * pp.p1) + half;
      dv[0].r[2] <= 53'(pp.adx * pp.p2) + half;
      dv[0].r[3] <= 53'(pp.ady * pp.p2) + half;
      dv[0].q    <= '0;
    end
  end

  for (genvar i = 0; i < Q_STEPS; i++) begin : g_dv
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[i + 1].vld <= 1'b0;
      end else if (en) begin
        dv[i + 1] <= dv_step(dv[i], i);
      end
    end
  end

  // Result register: apply the pushes and saturate.
  out_t res;
  always_ff @(posedge clk) begin
    if (rst) begin
      res.vld <= 1'b0;
    end else if (en) begin
      res.vld     <= dv[Q_STEPS].vld;
      res.contact <= dv[Q_STEPS].ovl;
      if (dv[Q_STEPS].ovl) begin
        res.nx1 <= sat_add(dv[Q_STEPS].x1, dv[Q_STEPS].sx, dv[Q_STEPS].q[0]);
        res.ny1 <= sat_add(dv[Q_STEPS].y1, dv[Q_STEPS].sy, dv[Q_STEPS].q[1]);
        res.nx2 <= sat_add(dv[Q_STEPS].x2, !dv[Q_STEPS].sx, dv[Q_STEPS].q[2]);
        res.ny2 <= sat_add(dv[Q_STEPS].y2, !dv[Q_STEPS].sy, dv[Q_STEPS].q[3]);
      end else begin
        res.nx1 <= dv[Q_STEPS].x1;
        res.ny1 <= dv[Q_STEPS].y1;
        res.nx2 <= dv[Q_STEPS].x2;
        res.ny2 <= dv[Q_STEPS].y2;
      end
    end
  end

  assign m_axis_tvalid = res.vld;
  assign m_axis_tdata  = {7'd0, res.contact, res.ny2, res.nx2, res.ny1, res.nx1};

`ifndef SYNTH
  // A stalled result holds the whole pipeline, so no word may be taken then.
  a_no_accept_on_stall : assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while result stalled");

  // An empty pipeline after reset shows no result.
  a_reset_empty : assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // The result register only changes when the pipeline advances.
  a_hold_on_stall : assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("stalled result changed");
`endif

endmodule
